/* rtl/key_gesture_classifier_defines.svh */
// Assertion macros for the key gesture classifier RTL.
`ifndef KEY_GESTURE_CLASSIFIER_DEFINES_SVH
`define KEY_GESTURE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KGC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("kgc assertion failed");

// Next-cycle implication, checked outside reset.
`define KGC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("kgc assertion failed");

`endif

/* rtl/kgc_pkg.sv */
// Types and constants of the key gesture classifier.
package kgc_pkg;

    localparam int unsigned CfgWidth     = 32;
    localparam int unsigned TimerWidth   = 32;
    localparam int unsigned ElapsedWidth = 16;

    localparam logic [CfgWidth-1:0] LongPressReset    = 32'd333;
    localparam logic [CfgWidth-1:0] DoubleWindowReset = 32'd333;

    // Configuration register indexes
    localparam logic CFG_LONG_PRESS    = 1'b0;
    localparam logic CFG_DOUBLE_WINDOW = 1'b1;

    // Item kinds carried on the input side
    localparam logic ACT_REPORT = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    typedef enum logic [2:0] {
        GEST_RELEASE      = 3'd0,
        GEST_PRESS        = 3'd1,
        GEST_LONG_PRESS   = 3'd2,
        GEST_CLICK        = 3'd3,
        GEST_LONG_CLICK   = 3'd4,
        GEST_DOUBLE_PRESS = 3'd5,
        GEST_DOUBLE_CLICK = 3'd6
    } gesture_t;

    typedef struct packed {
        logic                    action;
        logic                    key_down;
        logic [ElapsedWidth-1:0] elapsed;
    } kgc_item_t;

    typedef struct packed {
        gesture_t              gesture;
        logic                  key_level;
        logic [TimerWidth-1:0] held_time;
    } kgc_result_t;

endpackage

/* rtl/kgc_core.sv */
// Gesture state, configuration registers and per-item update logic.
`include "key_gesture_classifier_defines.svh"

module kgc_core
    import kgc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [CfgWidth-1:0] cfg_wdata,
    input  logic                step,
    input  kgc_item_t           item,
    output kgc_result_t         result
);

    logic [CfgWidth-1:0]   long_press_reg;
    logic [CfgWidth-1:0]   double_window_reg;
    logic                  level_reg, level_next;
    logic                  changed_reg, changed_next;
    logic [TimerWidth-1:0] timer_reg, timer_next;
    gesture_t              gesture_reg, gesture_next;
    logic                  pending_reg, pending_next;

    logic [TimerWidth:0]   sum_wide;
    logic [TimerWidth-1:0] timer_sat;
    logic [TimerWidth-1:0] timer_upd;

    // Saturating add of the elapsed time
    assign sum_wide  = {1'b0, timer_reg} + {{(TimerWidth+1-ElapsedWidth){1'b0}}, item.elapsed};
    assign timer_sat = sum_wide[TimerWidth] ? {TimerWidth{1'b1}} : sum_wide[TimerWidth-1:0];
    assign timer_upd = changed_reg ? '0 : timer_sat;

    // Next state for one item
    always_comb begin
        level_next   = level_reg;
        changed_next = changed_reg;
        timer_next   = timer_reg;
        gesture_next = gesture_reg;
        pending_next = pending_reg;
        if (item.action == ACT_REPORT) begin
            level_next   = item.key_down;
            changed_next = changed_reg | (item.key_down != level_reg);
        end else begin
            timer_next   = timer_upd;
            changed_next = 1'b0;
            unique case (gesture_reg)
                GEST_RELEASE: begin
                    if (changed_reg && level_reg && pending_reg &&
                        (timer_reg < double_window_reg)) begin
                        gesture_next = GEST_DOUBLE_PRESS;
                        pending_next = 1'b0;
                    end else if (changed_reg && level_reg) begin
                        gesture_next = GEST_PRESS;
                        pending_next = 1'b0;
                    end
                end
                GEST_PRESS: begin
                    if (!changed_reg && level_reg && (timer_upd >= long_press_reg)) begin
                        gesture_next = GEST_LONG_PRESS;
                        timer_next   = '0;
                    end else if (!level_reg) begin
                        gesture_next = GEST_CLICK;
                        pending_next = 1'b1;
                    end
                end
                GEST_LONG_PRESS: begin
                    if (!level_reg) begin
                        gesture_next = GEST_LONG_CLICK;
                        pending_next = 1'b1;
                    end
                end
                GEST_DOUBLE_PRESS: begin
                    if (!level_reg) begin
                        gesture_next = GEST_DOUBLE_CLICK;
                    end
                end
                default: begin
                    gesture_next = GEST_RELEASE;
                end
            endcase
        end
    end

    // Result shows the state after the item
    assign result.gesture   = gesture_next;
    assign result.key_level = level_next;
    assign result.held_time = timer_next;

    // Hold configuration and commit state on each step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_press_reg    <= LongPressReset;
            double_window_reg <= DoubleWindowReset;
            level_reg         <= 1'b0;
            changed_reg       <= 1'b0;
            timer_reg         <= '0;
            gesture_reg       <= GEST_RELEASE;
            pending_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_LONG_PRESS:    long_press_reg    <= cfg_wdata;
                    CFG_DOUBLE_WINDOW: double_window_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (step) begin
                level_reg   <= level_next;
                changed_reg <= changed_next;
                timer_reg   <= timer_next;
                gesture_reg <= gesture_next;
                pending_reg <= pending_next;
            end
        end
    end

    `KGC_ASSERT_NEXT(a_tick_clears_change, step && item.action == ACT_TICK, !changed_reg)
    `KGC_ASSERT_NEXT(a_long_press_zeroes_timer,
        step && gesture_reg == GEST_PRESS && gesture_next == GEST_LONG_PRESS, timer_reg == '0)
    `KGC_ASSERT_NEXT(a_click_sets_pending,
        step && (gesture_next == GEST_CLICK || gesture_next == GEST_LONG_CLICK), pending_reg)
    `KGC_ASSERT_NOW(a_report_keeps_gesture,
        step && item.action == ACT_REPORT, gesture_next == gesture_reg)

endmodule

/* rtl/key_gesture_classifier.sv */
// Top level of the key gesture classifier: input and result registers around the core.
// Path: each input transfer is held in the input register, then its result in the result register on the m_ side.
// Throughput: one item per cycle while m_tready does not stall the result register; the core commits state per item.
// Each item yields exactly one result transfer; s_tready follows m_tready when both stages hold.
// Reset (aresetn low, synchronous): gesture release, key released, timer zero,
// both time registers 333, pipeline empty.
module key_gesture_classifier
    import kgc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,   // [0] key_down, [16:1] elapsed, [23:17] zero
    input  logic                s_tuser,   // [0] action
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,   // [2:0] gesture, [3] key_level, [35:4] held_time
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [CfgWidth-1:0] cfg_wdata
);

    logic        in_valid_reg;
    kgc_item_t   in_item_reg;
    logic        out_valid_reg;
    kgc_result_t out_result_reg;
    kgc_result_t result;
    logic        advance;

    // Move an item into the result register when that register is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    kgc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .step      (advance),
        .item      (in_item_reg),
        .result    (result)
    );

    // Capture the input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.action   <= s_tuser;
            in_item_reg.key_down <= s_tdata[0];
            in_item_reg.elapsed  <= s_tdata[ElapsedWidth:1];
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_result_reg.held_time, out_result_reg.key_level,
                       out_result_reg.gesture};

endmodule
